/* design/srni_pkg.sv */
package srni_pkg;

  localparam int COORD_BITS = 16;
  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;
  localparam int NLANE = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic             vld;
    coord_t           ax;
    coord_t           ay;
    coord_t           tx;
    coord_t           ty;
    coord_t           rl;
    coord_t           rt;
    coord_t           rr;
    coord_t           rb;
    logic             vert;
    logic             horiz;
    logic [NLANE-1:0] neg;
  } side_t;

endpackage

/* design/srni_div.sv */
module srni_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [srni_pkg::P-1:0]  dvd,
  input  logic [srni_pkg::D-1:0]  dvs,
  output logic [srni_pkg::P-1:0]  quo
);

  logic [srni_pkg::D-1:0] rem_r [srni_pkg::P];
  logic [srni_pkg::P-1:0] sh_r  [srni_pkg::P];
  logic [srni_pkg::D-1:0] dvs_r [srni_pkg::P];

  genvar k;
  generate
    for (k = 0; k < srni_pkg::P; k++) begin : g_stage
      logic [srni_pkg::D-1:0] rem_in;
      logic [srni_pkg::P-1:0] sh_in;
      logic [srni_pkg::D-1:0] dvs_in;
      logic [srni_pkg::D:0]   trial;
      logic                   ge;
      logic [srni_pkg::D-1:0] rem_nxt;
      logic [srni_pkg::P-1:0] sh_nxt;

      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign sh_in  = dvd;
        assign dvs_in = dvs;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign sh_in  = sh_r[k-1];
        assign dvs_in = dvs_r[k-1];
      end

      always_comb begin
        trial   = {rem_in, sh_in[srni_pkg::P-1]};
        ge      = (trial >= {1'b0, dvs_in});
        rem_nxt = ge ? srni_pkg::D'(trial - {1'b0, dvs_in}) : trial[srni_pkg::D-1:0];
        sh_nxt  = {sh_in[srni_pkg::P-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          sh_r[k]  <= sh_nxt;
          dvs_r[k] <= dvs_in;
        end
      end
    end
  endgenerate

  assign quo = sh_r[srni_pkg::P-1];

endmodule

/* design/segment_rect_nearest_intersect.sv */
// Registered path: input register, products, the divider stages, candidates, squared distance, output register.
// Throughput: one word per cycle while the output is not stalled; four restoring dividers, one quotient bit per stage.
// The whole pipeline holds while the output word waits; in_ready = !out_valid | out_ready.
// Reset (rst_n low, synchronous) clears all valid bits; the data path is not reset.
module segment_rect_nearest_intersect (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  srni_pkg::coord_t        in_anchor_x,
  input  srni_pkg::coord_t        in_anchor_y,
  input  srni_pkg::coord_t        in_toward_x,
  input  srni_pkg::coord_t        in_toward_y,
  input  srni_pkg::coord_t        in_rect_left,
  input  srni_pkg::coord_t        in_rect_top,
  input  srni_pkg::coord_t        in_rect_right,
  input  srni_pkg::coord_t        in_rect_bottom,
  output logic                    out_valid,
  input  logic                    out_ready,
  output srni_pkg::coord_t        out_hit_x,
  output srni_pkg::coord_t        out_hit_y,
  output logic                    out_hit_found
);

  localparam int C = srni_pkg::COORD_BITS;
  localparam int D = srni_pkg::D;
  localparam int P = srni_pkg::P;
  localparam int N = srni_pkg::NLANE;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: input register
  srni_pkg::side_t s1_r, s1_nxt;
  always_comb begin
    s1_nxt       = '0;
    s1_nxt.vld   = in_valid;
    s1_nxt.ax    = in_anchor_x;
    s1_nxt.ay    = in_anchor_y;
    s1_nxt.tx    = in_toward_x;
    s1_nxt.ty    = in_toward_y;
    s1_nxt.rl    = in_rect_left;
    s1_nxt.rt    = in_rect_top;
    s1_nxt.rr    = in_rect_right;
    s1_nxt.rb    = in_rect_bottom;
    s1_nxt.vert  = (in_toward_x == in_anchor_x);
    s1_nxt.horiz = (in_toward_y == in_anchor_y);
  end

  // stage 2: products and divisors
  logic signed [D-1:0] dx, dy;
  logic signed [D-1:0] num [N];
  logic        [D-1:0] nmag [N];
  logic        [D-1:0] dxm, dym;
  srni_pkg::side_t     s2_r, s2_nxt;
  logic [P-1:0]        prod_r [N];
  logic [P-1:0]        prod_nxt [N];
  logic [D-1:0]        dxm_r, dym_r;

  always_comb begin
    dx     = D'(s1_r.tx) - D'(s1_r.ax);
    dy     = D'(s1_r.ty) - D'(s1_r.ay);
    num[0] = D'(s1_r.rt) - D'(s1_r.ay);
    num[1] = D'(s1_r.rb) - D'(s1_r.ay);
    num[2] = D'(s1_r.rl) - D'(s1_r.ax);
    num[3] = D'(s1_r.rr) - D'(s1_r.ax);
    dxm    = dx[D-1] ? D'(-dx) : D'(dx);
    dym    = dy[D-1] ? D'(-dy) : D'(dy);
    s2_nxt = s1_r;
    for (int i = 0; i < N; i++) begin
      nmag[i]        = num[i][D-1] ? D'(-num[i]) : D'(num[i]);
      prod_nxt[i]    = P'(nmag[i]) * P'(i < 2 ? dxm : dym);
      s2_nxt.neg[i]  = num[i][D-1] ^ dx[D-1] ^ dy[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
    if (en) begin
      prod_r  <= prod_nxt;
      dxm_r   <= dxm;
      dym_r   <= dym;
    end
  end

  // dividers
  logic [P-1:0] quo [N];
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_lane
      srni_div u_div (
        .clk (clk),
        .en  (en),
        .dvd (prod_r[g]),
        .dvs ((g < 2) ? dym_r : dxm_r),
        .quo (quo[g])
      );
    end
  endgenerate

  srni_pkg::side_t sd_r [P];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < P; i++) sd_r[i].vld <= 1'b0;
    end else if (en) begin
      sd_r[0] <= s2_r;
      for (int i = 1; i < P; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  // stage 3: candidates and bounds check
  srni_pkg::side_t sdo;
  assign sdo = sd_r[P-1];
  logic signed [P:0]   qs [N];
  logic signed [P+1:0] cv [N];
  srni_pkg::coord_t    cx_nxt [N], cy_nxt [N];
  logic [N-1:0]        ok_nxt;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      qs[i] = sdo.neg[i] ? (P+1)'(-$signed({1'b0, quo[i]})) : $signed({1'b0, quo[i]});
      cv[i] = (P+2)'((i < 2) ? sdo.ax : sdo.ay) + (P+2)'(qs[i]);
    end
    cx_nxt[0] = cv[0][C-1:0]; cy_nxt[0] = sdo.rt;
    cx_nxt[1] = cv[1][C-1:0]; cy_nxt[1] = sdo.rb;
    cx_nxt[2] = sdo.rl;       cy_nxt[2] = cv[2][C-1:0];
    cx_nxt[3] = sdo.rr;       cy_nxt[3] = cv[3][C-1:0];
    ok_nxt[0] = !sdo.horiz && cv[0] >= (P+2)'(sdo.rl) && cv[0] <= (P+2)'(sdo.rr)
                && sdo.rt <= sdo.rb;
    ok_nxt[1] = !sdo.horiz && cv[1] >= (P+2)'(sdo.rl) && cv[1] <= (P+2)'(sdo.rr)
                && sdo.rt <= sdo.rb;
    ok_nxt[2] = cv[2] >= (P+2)'(sdo.rt) && cv[2] <= (P+2)'(sdo.rb) && sdo.rl <= sdo.rr;
    ok_nxt[3] = cv[3] >= (P+2)'(sdo.rt) && cv[3] <= (P+2)'(sdo.rb) && sdo.rl <= sdo.rr;
  end

  srni_pkg::side_t  s3_r, s4_r;
  srni_pkg::coord_t cx_r [N], cy_r [N], cx4_r [N], cy4_r [N];
  logic [N-1:0]     ok_r, ok4_r;
  logic [P:0]       dist_r [N], dist_nxt [N];

  // stage 4: squared distance
  logic signed [D-1:0] ex [N], ey [N];
  logic [D-1:0]        exm [N], eym [N];
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ex[i]       = D'(cx_r[i]) - D'(s3_r.tx);
      ey[i]       = D'(cy_r[i]) - D'(s3_r.ty);
      exm[i]      = ex[i][D-1] ? D'(-ex[i]) : D'(ex[i]);
      eym[i]      = ey[i][D-1] ? D'(-ey[i]) : D'(ey[i]);
      dist_nxt[i] = (P+1)'(P'(exm[i]) * P'(exm[i])) + (P+1)'(P'(eym[i]) * P'(eym[i]));
    end
  end

  // stage 5: nearest pick
  srni_pkg::coord_t hx_nxt, hy_nxt;
  logic             hf_nxt;
  logic [P:0]       best;
  always_comb begin
    hx_nxt = '0;
    hy_nxt = '0;
    hf_nxt = 1'b0;
    best   = '0;
    if (s4_r.vert) begin
      hx_nxt = s4_r.ax;
      hy_nxt = (s4_r.ty < s4_r.ay) ? s4_r.rt : s4_r.rb;
      hf_nxt = 1'b1;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (ok4_r[i] && (!hf_nxt || dist_r[i] < best)) begin
          hf_nxt = 1'b1;
          best   = dist_r[i];
          hx_nxt = cx4_r[i];
          hy_nxt = cy4_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.vld  <= 1'b0;
      s4_r.vld  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s3_r      <= sdo;
      s4_r      <= s3_r;
      out_valid <= s4_r.vld;
    end
    if (en) begin
      cx_r          <= cx_nxt;
      cy_r          <= cy_nxt;
      ok_r          <= ok_nxt;
      cx4_r         <= cx_r;
      cy4_r         <= cy_r;
      ok4_r         <= ok_r;
      dist_r        <= dist_nxt;
      out_hit_x     <= hx_nxt;
      out_hit_y     <= hy_nxt;
      out_hit_found <= hf_nxt;
    end
  end

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow output stall");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit_found |-> out_hit_x == '0 && out_hit_y == '0)
    else $error("miss word carries nonzero point");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

/* tb/tb_segment_rect_nearest_intersect.sv */
module tb_segment_rect_nearest_intersect;
  timeunit 1ns;
  timeprecision 1ps;

  typedef srni_pkg::coord_t coord_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    coord_t     c[8];
    idle_mode_t mode;
    bit         drain;
  } seg_word_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   found;
  } hit_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 60;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_c[8];
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_hit_x, out_hit_y;
  logic   out_hit_found;

  seg_word_t  seg_q[$];
  hit_t       hit_q[$];
  idle_mode_t cur_mode = IDLE_NONE;
  bit         taken = 1'b0;
  int         n_err = 0, n_sent = 0, n_got = 0, n_found = 0, stall_cnt = 0;

  initial for (int i = 0; i < 8; i++) in_c[i] = '0;

  always #10 clk = ~clk;

  segment_rect_nearest_intersect DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_anchor_x(in_c[0]), .in_anchor_y(in_c[1]),
    .in_toward_x(in_c[2]), .in_toward_y(in_c[3]),
    .in_rect_left(in_c[4]), .in_rect_top(in_c[5]),
    .in_rect_right(in_c[6]), .in_rect_bottom(in_c[7]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit_x(out_hit_x), .out_hit_y(out_hit_y), .out_hit_found(out_hit_found)
  );

  function automatic hit_t nearest_crossing(coord_t c[8]);
    longint ax, ay, tx, ty, rl, rt, rr, rb, dx, dy, d, best_d;
    longint cx[4], cy[4];
    bit use_c[4];
    bit ok;
    hit_t h;
    ax = c[0]; ay = c[1]; tx = c[2]; ty = c[3];
    rl = c[4]; rt = c[5]; rr = c[6]; rb = c[7];
    dx = tx - ax;
    dy = ty - ay;
    h = '{x: '0, y: '0, found: 1'b0};
    if (dx == 0) begin
      h.x = coord_t'(ax);
      h.y = (ty < ay) ? coord_t'(rt) : coord_t'(rb);
      h.found = 1'b1;
      return h;
    end
    use_c[0] = (dy != 0);
    use_c[1] = (dy != 0);
    use_c[2] = 1'b1;
    use_c[3] = 1'b1;
    if (dy != 0) begin
      cx[0] = ax + ((rt - ay) * dx) / dy; cy[0] = rt;
      cx[1] = ax + ((rb - ay) * dx) / dy; cy[1] = rb;
    end
    cx[2] = rl; cy[2] = ay + ((rl - ax) * dy) / dx;
    cx[3] = rr; cy[3] = ay + ((rr - ax) * dy) / dx;
    ok = 1'b0;
    best_d = 0;
    for (int i = 0; i < 4; i++) begin
      if (use_c[i] && cx[i] >= rl && cx[i] <= rr && cy[i] >= rt && cy[i] <= rb) begin
        d = (cx[i] - tx) * (cx[i] - tx) + (cy[i] - ty) * (cy[i] - ty);
        if (!ok || d < best_d) begin
          ok = 1'b1;
          best_d = d;
          h.x = coord_t'(cx[i]);
          h.y = coord_t'(cy[i]);
        end
      end
    end
    h.found = ok;
    return h;
  endfunction

  function automatic coord_t rnd_near(longint base, int span);
    longint v;
    v = base + longint'($urandom_range(2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  task automatic add_word(coord_t ax, coord_t ay, coord_t tx, coord_t ty,
                          coord_t rl, coord_t rt, coord_t rr, coord_t rb,
                          idle_mode_t mode, bit drain);
    seg_word_t w;
    w.c = '{ax, ay, tx, ty, rl, rt, rr, rb};
    w.mode = mode;
    w.drain = drain;
    seg_q.push_back(w);
  endtask

  // mostly a proper rectangle with the anchor on a side; some pure noise
  task automatic add_random(idle_mode_t mode, bit drain);
    coord_t c[8];
    coord_t a, b;
    int span, kind;
    span = ($urandom_range(9) == 0) ? 32767 : $urandom_range(1, 300);
    kind = $urandom_range(19);
    if (kind < 3) begin
      for (int i = 0; i < 8; i++) c[i] = coord_t'($urandom);
    end else begin
      a = coord_t'($urandom); b = rnd_near(a, span);
      c[4] = (a < b) ? a : b; c[6] = (a < b) ? b : a;
      a = coord_t'($urandom); b = rnd_near(a, span);
      c[5] = (a < b) ? a : b; c[7] = (a < b) ? b : a;
      case ($urandom_range(3))
        0: begin c[0] = c[4]; c[1] = rnd_near(c[5], span); end
        1: begin c[0] = c[6]; c[1] = rnd_near(c[7], span); end
        2: begin c[0] = rnd_near(c[4], span); c[1] = c[5]; end
        default: begin c[0] = rnd_near(c[6], span); c[1] = c[7]; end
      endcase
      c[2] = rnd_near(c[0], 2 * span);
      c[3] = rnd_near(c[1], 2 * span);
      if (kind == 3) c[2] = c[0];
      if (kind == 4) c[3] = c[1];
      if (kind == 5) begin c[4] = c[6] + 1; end
    end
    add_word(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], mode, drain);
  endtask

  initial begin
    idle_mode_t modes[4];
    modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    // vertical up, down, with inverted rectangle
    add_word(0, 0, 0, -5, -10, -10, 10, 10, IDLE_NONE, 0);
    add_word(0, 0, 0, 5, -10, -10, 10, 10, IDLE_NONE, 0);
    add_word(0, 0, 0, 0, -10, -10, 10, 10, IDLE_NONE, 0);
    add_word(3, 3, 3, 1, 10, 10, -10, -10, IDLE_NONE, 0);
    // horizontal
    add_word(-10, 2, 5, 2, -10, -10, 10, 10, IDLE_NONE, 0);
    add_word(-10, 2, -20, 2, -10, -10, 10, 10, IDLE_NONE, 0);
    // diagonal, ties at corners
    add_word(-10, -10, 10, 10, -10, -10, 10, 10, IDLE_NONE, 0);
    add_word(-10, 0, 0, 7, -10, -10, 10, 10, IDLE_NONE, 0);
    add_word(0, 0, 3, -7, -10, -10, 10, 10, IDLE_NONE, 0);
    // no crossing, inverted rectangles
    add_word(100, 100, 200, 300, -10, -10, 10, 10, IDLE_NONE, 0);
    add_word(0, 0, 4, 3, 10, -10, -10, 10, IDLE_NONE, 0);
    add_word(0, 0, 4, 3, -10, 10, 10, -10, IDLE_NONE, 0);
    // extremes
    add_word(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, IDLE_NONE, 0);
    add_word(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767, IDLE_NONE, 0);
    add_word(-32768, 0, 32767, 1, -32768, -32768, 32767, 32767, IDLE_NONE, 0);
    add_word(0, -32768, 1, 32767, -32768, -32768, 32767, 32767, IDLE_NONE, 0);
    add_word(-32768, -32768, -32767, 32767, -32768, -32768, 32767, 32767, IDLE_NONE, 0);
    add_word(32767, 32767, -32768, 32766, -1, -1, 0, 0, IDLE_NONE, 0);
    add_word(-32768, 32767, 32767, -32768, 0, 0, 0, 0, IDLE_NONE, 0);
    add_word(5, 5, 6, 5, 5, 5, 5, 5, IDLE_NONE, 0);
    for (int p = 0; p < 8; p++)
      for (int i = 0; i < 230; i++)
        add_random(modes[p % 4], (i == 0) || (p == 3 && i == 100));
  end

  // sender
  always @(negedge clk) begin
    bit idle;
    seg_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !taken)) begin
      idle = 1'b0;
      if (seg_q.size() == 0) begin
        idle = 1'b1;
      end else begin
        cur_mode = seg_q[0].mode;
        if (seg_q[0].drain) begin
          if (hit_q.size() == 0 && !in_valid) seg_q[0].drain = 1'b0;
          idle = 1'b1;
        end else if ((cur_mode == IDLE_SEND && $urandom_range(99) < 46) ||
                     (cur_mode == IDLE_BOTH && $urandom_range(99) < 31)) begin
          idle = 1'b1;
        end
      end
      if (idle) begin
        in_valid <= 1'b0;
      end else begin
        w = seg_q.pop_front();
        for (int i = 0; i < 8; i++) in_c[i] <= w.c[i];
        in_valid <= 1'b1;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n)
      out_ready <= 1'b0;
    else if (cur_mode == IDLE_RECV)
      out_ready <= ($urandom_range(99) >= 46);
    else if (cur_mode == IDLE_BOTH)
      out_ready <= ($urandom_range(99) >= 31);
    else
      out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    hit_t e;
    taken = rst_n && in_valid && in_ready;
    if (taken) begin
      hit_q.push_back(nearest_crossing(in_c));
      n_sent++;
    end
    if (rst_n && out_valid && out_ready) begin
      n_got++;
      if (hit_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected word: x=%0d y=%0d found=%0b",
                                  out_hit_x, out_hit_y, out_hit_found);
      end else begin
        e = hit_q.pop_front();
        if (e.found) n_found++;
        if (out_hit_x !== e.x || out_hit_y !== e.y || out_hit_found !== e.found) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch word %0d: exp x=%0d y=%0d found=%0b got x=%0d y=%0d found=%0b",
                     n_got, e.x, e.y, e.found, out_hit_x, out_hit_y, out_hit_found);
        end
      end
    end
    if (taken || (out_valid && out_ready)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (seg_q.size() == 0 && n_sent > 0 && hit_q.size() == 0 && !in_valid);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (hit_q.size() != 0) n_err++;
    $display("sent %0d words, checked %0d results (%0d with a crossing)",
             n_sent, n_got, n_found);
    $display("covered vertical, horizontal, inverted and extreme cases under four idle mixes");
    if (n_err == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/srni_pkg.sv
design/srni_div.sv
design/segment_rect_nearest_intersect.sv
tb/tb_segment_rect_nearest_intersect.sv
